[rtl/core/chm_pkg.sv]
// Shared constants and codes for the chained hash map core.
// No dependencies; imported by chm_hash and chained_hash_map_u64_core.
package chm_pkg;

    localparam int KEY_W    = 64;
    localparam int HASH_W   = 32;
    localparam int HANDLE_W = 10;
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;

    localparam int SH_A = 18;
    localparam int SH_B = 31;
    localparam int SH_C = 11;
    localparam int SH_D = 6;
    localparam int SH_E = 22;
    localparam int HASH_STEPS = 6;

    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_DELETE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NO_CUR    = 2'd3;

endpackage

[rtl/core/chm_hash.sv]
// Iterative 64-to-32 shift hash followed by a reciprocal-multiply modulo reduction.
// Depends on chm_pkg.
module chm_hash #(
    parameter int BUCKETS = 1021
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [chm_pkg::KEY_W-1:0]   key,
    output logic                        done,
    output logic [$clog2(BUCKETS)-1:0]  bucket
);
    import chm_pkg::*;

    localparam int BW        = $clog2(BUCKETS);
    localparam int LO_W      = 16;
    localparam int MW        = 17;
    localparam int PW        = HASH_W + MW;
    localparam int AW        = PW + LO_W;
    localparam int SHIFT     = HASH_W + BW;
    localparam int MOD_STEPS = 4;
    localparam int CW        = $clog2(HASH_STEPS);
    localparam logic [63:0]       RECIP    = (64'd1 << SHIFT) / 64'(BUCKETS);
    localparam logic [MW-1:0]     RECIP_LO = {1'b0, RECIP[LO_W-1:0]};
    localparam logic [MW-1:0]     RECIP_HI = RECIP[LO_W+MW-1:LO_W];
    localparam logic [MW-1:0]     BMOD_M   = MW'(BUCKETS);
    localparam logic [HASH_W-1:0] BMOD     = HASH_W'(BUCKETS);

    typedef enum logic [1:0] {H_IDLE, H_MIX, H_MOD} hstate_t;

    hstate_t            state_reg;
    logic [CW-1:0]      cnt_reg;
    logic [KEY_W-1:0]   h_reg;
    logic [KEY_W-1:0]   h_next;
    logic [AW-1:0]      acc_reg;
    logic [HASH_W-1:0]  r_reg;
    logic [HASH_W-1:0]  r_fix;
    logic [HASH_W-1:0]  q_est;
    logic [HASH_W-1:0]  mul_a;
    logic [MW-1:0]      mul_b;
    logic [PW-1:0]      mul_p;
    logic               done_reg;

    always_comb
    begin
        case (cnt_reg)
            CW'(0):  h_next = ~h_reg + (h_reg << SH_A);
            CW'(1):  h_next = h_reg ^ (h_reg >> SH_B);
            CW'(2):  h_next = (h_reg << 4) + (h_reg << 2) + h_reg;
            CW'(3):  h_next = h_reg ^ (h_reg >> SH_C);
            CW'(4):  h_next = h_reg + (h_reg << SH_D);
            default: h_next = h_reg ^ (h_reg >> SH_E);
        endcase
        q_est = HASH_W'(acc_reg >> SHIFT);
        mul_a = h_reg[HASH_W-1:0];
        mul_b = RECIP_LO;
        case (cnt_reg)
            CW'(1):  mul_b = RECIP_HI;
            CW'(2):
            begin
                mul_a = q_est;
                mul_b = BMOD_M;
            end
            default: ;
        endcase
        mul_p = PW'(mul_a) * PW'(mul_b);
        r_fix = (r_reg >= BMOD) ? (r_reg - BMOD) : r_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= H_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                H_IDLE:
                begin
                    if (start)
                    begin
                        h_reg     <= key;
                        cnt_reg   <= '0;
                        state_reg <= H_MIX;
                    end
                end
                H_MIX:
                begin
                    h_reg <= h_next;
                    if (cnt_reg == CW'(HASH_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= H_MOD;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                H_MOD:
                begin
                    case (cnt_reg)
                        CW'(0):  acc_reg <= AW'(mul_p);
                        CW'(1):  acc_reg <= acc_reg + {mul_p, {LO_W{1'b0}}};
                        CW'(2):  r_reg <= h_reg[HASH_W-1:0] - mul_p[HASH_W-1:0];
                        default: r_reg <= r_fix;
                    endcase
                    if (cnt_reg == CW'(MOD_STEPS - 1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= H_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                default: state_reg <= H_IDLE;
            endcase
        end
    end

    assign done   = done_reg;
    assign bucket = r_reg[BW-1:0];

endmodule

[rtl/core/chained_hash_map_u64_core.sv]
// Chained hash set of 64-bit keys over a fixed node pool, with a cursor.
// Depends on chm_pkg and chm_hash.
// A lookup or insert hashes the key, reads the bucket head and walks its chain node by node,
// stopping on a hit; an insert that misses then adds the key. A delete walks the cursor's bucket
// chain up to and including the deleted node, or answers ST_NO_CUR with no current entry.
// One operation at a time; in_ready is low until the result enters the output register.
// After reset every bucket head is cleared to NIL before in_ready rises.
module chained_hash_map_u64_core #(
    parameter int BUCKETS = 1021,
    parameter int NODES   = 1024
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [chm_pkg::OP_W-1:0]        operation,
    input  logic [chm_pkg::KEY_W-1:0]       key,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic                            found,
    output logic                            is_new,
    output logic [chm_pkg::HANDLE_W-1:0]    handle,
    output logic [chm_pkg::STATUS_W-1:0]    status
);
    import chm_pkg::*;

    localparam int BW = $clog2(BUCKETS);
    localparam int IW = $clog2(NODES);
    localparam int NW = $clog2(NODES + 1);
    localparam logic [NW-1:0] NIL = NW'(NODES);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_HASH, S_HEAD_RD, S_HEAD, S_NODE_RD, S_NODE_CMP,
        S_DEL, S_INS, S_RESP
    } state_t;

    logic [NW-1:0]    bucket_head [BUCKETS];
    logic [KEY_W-1:0] node_key    [NODES];
    logic [NW-1:0]    node_next   [NODES];
    logic [IW-1:0]    free_mem    [NODES];

    state_t           state_reg;
    logic [BW-1:0]    clr_reg;
    logic [OP_W-1:0]  op_reg;
    logic [KEY_W-1:0] key_reg;
    logic [BW-1:0]    b_reg;
    logic [NW-1:0]    n_reg;
    logic [NW-1:0]    prev_reg;
    logic [NW-1:0]    steps_reg;
    logic [NW-1:0]    count_reg;
    logic [NW-1:0]    hw_reg;
    logic [BW-1:0]    cur_b_reg;
    logic [NW-1:0]    cur_n_reg;
    logic             res_found_reg;
    logic             res_new_reg;
    logic [NW-1:0]    res_handle_reg;
    logic [STATUS_W-1:0] res_status_reg;
    logic             out_valid_reg;
    logic             found_reg;
    logic             is_new_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [STATUS_W-1:0] status_reg;

    logic [NW-1:0]    head_rd_reg;
    logic [KEY_W-1:0] key_rd_reg;
    logic [NW-1:0]    next_rd_reg;
    logic [IW-1:0]    free_rd_reg;

    logic             hash_start_reg;
    logic             hash_done;
    logic [BW-1:0]    hash_bucket;

    logic             head_we;
    logic [BW-1:0]    head_waddr;
    logic [NW-1:0]    head_wdata;
    logic             next_we;
    logic [IW-1:0]    next_waddr;
    logic [NW-1:0]    next_wdata;
    logic             free_we;
    logic [NW-1:0]    count_dec;
    logic [NW-1:0]    fresh;
    logic             is_del;
    logic             walk_end;

    chm_hash #(.BUCKETS(BUCKETS)) u_hash (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (hash_start_reg),
        .key    (key_reg),
        .done   (hash_done),
        .bucket (hash_bucket)
    );

    always_comb
    begin
        is_del     = (op_reg == OP_DELETE);
        walk_end   = (n_reg == NIL) || (steps_reg == NIL);
        count_dec  = count_reg - 1'b1;
        fresh      = (count_reg < hw_reg) ? NW'(free_rd_reg) : count_reg;
        head_we    = 1'b0;
        head_waddr = b_reg;
        head_wdata = fresh;
        next_we    = 1'b0;
        next_waddr = fresh[IW-1:0];
        next_wdata = head_rd_reg;
        free_we    = 1'b0;
        case (state_reg)
            S_CLEAR:
            begin
                head_we    = 1'b1;
                head_waddr = clr_reg;
                head_wdata = NIL;
            end
            S_INS:
            begin
                head_we = 1'b1;
                next_we = 1'b1;
            end
            S_DEL:
            begin
                free_we = 1'b1;
                if (prev_reg == NIL)
                begin
                    head_we    = 1'b1;
                    head_wdata = next_rd_reg;
                end
                else
                begin
                    next_we    = 1'b1;
                    next_waddr = prev_reg[IW-1:0];
                    next_wdata = next_rd_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (head_we)
        begin
            bucket_head[head_waddr] <= head_wdata;
        end
        head_rd_reg <= bucket_head[b_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_INS)
        begin
            node_key[fresh[IW-1:0]] <= key_reg;
        end
        key_rd_reg <= node_key[n_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            node_next[next_waddr] <= next_wdata;
        end
        next_rd_reg <= node_next[n_reg[IW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (free_we)
        begin
            free_mem[count_dec[IW-1:0]] <= n_reg[IW-1:0];
        end
        free_rd_reg <= free_mem[count_reg[IW-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            count_reg      <= '0;
            hw_reg         <= '0;
            cur_b_reg      <= '0;
            cur_n_reg      <= NIL;
            out_valid_reg  <= 1'b0;
            hash_start_reg <= 1'b0;
        end
        else
        begin
            hash_start_reg <= 1'b0;
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_CLEAR:
                begin
                    if (clr_reg == BW'(BUCKETS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        clr_reg <= clr_reg + 1'b1;
                    end
                end
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg         <= operation;
                        key_reg        <= key;
                        res_found_reg  <= 1'b0;
                        res_new_reg    <= 1'b0;
                        res_handle_reg <= '0;
                        if (operation == OP_DELETE)
                        begin
                            if (cur_n_reg == NIL)
                            begin
                                res_status_reg <= ST_NO_CUR;
                                state_reg      <= S_RESP;
                            end
                            else
                            begin
                                b_reg     <= cur_b_reg;
                                state_reg <= S_HEAD_RD;
                            end
                        end
                        else
                        begin
                            hash_start_reg <= 1'b1;
                            state_reg      <= S_HASH;
                        end
                    end
                end
                S_HASH:
                begin
                    if (hash_done)
                    begin
                        b_reg     <= hash_bucket;
                        state_reg <= S_HEAD_RD;
                    end
                end
                S_HEAD_RD: state_reg <= S_HEAD;
                S_HEAD:
                begin
                    n_reg     <= head_rd_reg;
                    prev_reg  <= NIL;
                    steps_reg <= '0;
                    state_reg <= S_NODE_RD;
                end
                S_NODE_RD:
                begin
                    if (is_del && n_reg == cur_n_reg)
                    begin
                        state_reg <= S_DEL;
                    end
                    else if (walk_end)
                    begin
                        if (is_del)
                        begin
                            cur_n_reg      <= NIL;
                            res_status_reg <= ST_NO_CUR;
                        end
                        else if (op_reg != OP_INSERT)
                        begin
                            res_status_reg <= ST_NOT_FOUND;
                        end
                        else if (count_reg == NIL)
                        begin
                            res_status_reg <= ST_FULL;
                        end
                        state_reg <= (!is_del && op_reg == OP_INSERT && count_reg != NIL)
                                     ? S_INS : S_RESP;
                    end
                    else
                    begin
                        state_reg <= S_NODE_CMP;
                    end
                end
                S_NODE_CMP:
                begin
                    if (!is_del && key_rd_reg == key_reg)
                    begin
                        cur_b_reg      <= b_reg;
                        cur_n_reg      <= n_reg;
                        res_found_reg  <= 1'b1;
                        res_handle_reg <= n_reg;
                        res_status_reg <= ST_OK;
                        state_reg      <= S_RESP;
                    end
                    else
                    begin
                        prev_reg  <= n_reg;
                        n_reg     <= next_rd_reg;
                        steps_reg <= steps_reg + 1'b1;
                        state_reg <= S_NODE_RD;
                    end
                end
                S_DEL:
                begin
                    count_reg      <= count_dec;
                    cur_n_reg      <= NIL;
                    res_handle_reg <= n_reg;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_RESP;
                end
                S_INS:
                begin
                    count_reg      <= count_reg + 1'b1;
                    if (count_reg == hw_reg)
                    begin
                        hw_reg <= count_reg + 1'b1;
                    end
                    cur_b_reg      <= b_reg;
                    cur_n_reg      <= fresh;
                    res_new_reg    <= 1'b1;
                    res_handle_reg <= fresh;
                    res_status_reg <= ST_OK;
                    state_reg      <= S_RESP;
                end
                S_RESP:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        found_reg     <= res_found_reg;
                        is_new_reg    <= res_new_reg;
                        handle_reg    <= HANDLE_W'(res_handle_reg);
                        status_reg    <= res_status_reg;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign found     = found_reg;
    assign is_new    = is_new_reg;
    assign handle    = handle_reg;
    assign status    = status_reg;

endmodule

[dv/chained_hash_map_u64_core_test.sv]
// Self-checking testbench for chained_hash_map_u64_core: a local model of the chained hash set
// predicts every result, with directed, random, pool-full and backpressure tests.
// Depends on chm_pkg and the core RTL only.
`timescale 1ns / 1ps

module chained_hash_map_u64_core_test;
    import chm_pkg::*;

    localparam int BUCKETS = 1021;
    localparam int NODES = 1024;
    localparam int NIL = NODES;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

    typedef struct packed {
        logic                found;
        logic                is_new;
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
    } map_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [OP_W-1:0]     operation;
    logic [KEY_W-1:0]    key;
    logic                out_valid;
    logic                out_ready;
    logic                found;
    logic                is_new;
    logic [HANDLE_W-1:0] handle;
    logic [STATUS_W-1:0] status;

    int                  chain_head [BUCKETS];
    logic [KEY_W-1:0]    slot_key [NODES];
    int                  slot_next [NODES];
    int                  free_stack [NODES];
    int                  live_count;
    int                  cur_bucket;
    int                  cur_node;

    map_result_t         pending_results [$];
    logic [KEY_W-1:0]    known_keys [$];
    int                  error_count;
    int                  result_count;
    int                  cycle_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  hold_left;
    int                  hold_asked;
    int                  hold_taken;

    chained_hash_map_u64_core #(
        .BUCKETS(BUCKETS),
        .NODES(NODES)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .operation(operation),
        .key(key),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .found(found),
        .is_new(is_new),
        .handle(handle),
        .status(status)
    );

    always #10 clk = ~clk;

    function automatic int bucket_of(logic [KEY_W-1:0] k);
        logic [63:0] h;
        logic [31:0] low;
        begin
            h = ~k + (k << SH_A);
            h = h ^ (h >> SH_B);
            h = h * 64'd21;
            h = h ^ (h >> SH_C);
            h = h + (h << SH_D);
            h = h ^ (h >> SH_E);
            low = h[31:0];
            return int'(low % BUCKETS);
        end
    endfunction

    function automatic void clear_model();
        for (int i = 0; i < BUCKETS; i++)
        begin
            chain_head[i] = NIL;
        end
        for (int i = 0; i < NODES; i++)
        begin
            slot_next[i] = NIL;
            slot_key[i] = '0;
            free_stack[i] = NODES - 1 - i;
        end
        live_count = 0;
        cur_bucket = 0;
        cur_node = NIL;
    endfunction

    function automatic map_result_t apply_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
        map_result_t r;
        int b;
        int n;
        int prev;
        int steps;
        int fresh;
        begin
            r = '0;
            if (op == OP_DELETE)
            begin
                if (cur_node >= NIL)
                begin
                    r.status = ST_NO_CUR;
                    return r;
                end
                b = cur_bucket;
                n = chain_head[b];
                prev = NIL;
                steps = 0;
                while (n < NIL && n != cur_node && steps < NODES)
                begin
                    prev = n;
                    n = slot_next[n];
                    steps++;
                end
                if (n != cur_node)
                begin
                    cur_node = NIL;
                    r.status = ST_NO_CUR;
                    return r;
                end
                cur_node = NIL;
                if (prev == NIL)
                    chain_head[b] = slot_next[n];
                else
                    slot_next[prev] = slot_next[n];
                if (live_count > 0)
                begin
                    live_count--;
                    free_stack[NODES - 1 - live_count] = n;
                end
                r.handle = HANDLE_W'(n);
                r.status = ST_OK;
                return r;
            end
            b = bucket_of(k);
            n = chain_head[b];
            steps = 0;
            while (n < NIL && steps < NODES && slot_key[n] != k)
            begin
                n = slot_next[n];
                steps++;
            end
            if (n < NIL && steps < NODES)
            begin
                cur_bucket = b;
                cur_node = n;
                r.found = 1'b1;
                r.handle = HANDLE_W'(n);
                r.status = ST_OK;
                return r;
            end
            if (op != OP_INSERT)
            begin
                r.status = ST_NOT_FOUND;
                return r;
            end
            if (live_count >= NODES)
            begin
                r.status = ST_FULL;
                return r;
            end
            fresh = free_stack[NODES - 1 - live_count];
            live_count++;
            slot_key[fresh] = k;
            slot_next[fresh] = chain_head[b];
            chain_head[b] = fresh;
            cur_bucket = b;
            cur_node = fresh;
            known_keys.push_back(k);
            r.is_new = 1'b1;
            r.handle = HANDLE_W'(fresh);
            r.status = ST_OK;
            return r;
        end
    endfunction

    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        begin
            k = {$urandom, $urandom};
            case ($urandom_range(15))
                0: k = '0;
                1: k = '1;
                2: k = {32'h0, k[31:0]};
                3: k = {k[63:32], 32'hFFFF_FFFF};
                default: ;
            endcase
            return k;
        end
    endfunction

    function automatic logic [KEY_W-1:0] pick_key();
        if (known_keys.size() > 0 && $urandom_range(99) < 60)
            return known_keys[$urandom_range(known_keys.size() - 1)];
        return random_key();
    endfunction

    function automatic logic [KEY_W-1:0] key_in_bucket(int target);
        logic [KEY_W-1:0] k;
        begin
            k = {$urandom, $urandom};
            while (bucket_of(k) != target)
            begin
                k = {$urandom, $urandom};
            end
            return k;
        end
    endfunction

    task automatic send_op(logic [OP_W-1:0] op, logic [KEY_W-1:0] k);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        in_valid <= 1'b1;
        operation <= op;
        key <= k;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(apply_op(op, k));
    endtask

    task automatic wait_all_done();
        in_valid <= 1'b0;
        while (pending_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic test_directed();
        logic [KEY_W-1:0] chain_keys [4];
        int target;
        begin
            target = $urandom_range(BUCKETS - 1);
            for (int i = 0; i < 4; i++)
            begin
                chain_keys[i] = key_in_bucket(target);
            end
            send_op(OP_DELETE, '1);
            send_op(OP_INSERT, '0);
            send_op(OP_INSERT, '1);
            send_op(OP_LOOKUP, '0);
            send_op(OP_LOOKUP, '1);
            send_op(OP_SPARE, '1);
            send_op(OP_SPARE, 64'h0123_4567_89AB_CDEF);
            send_op(OP_LOOKUP, 64'h8000_0000_0000_0001);
            send_op(OP_INSERT, '1);
            send_op(OP_DELETE, '0);
            send_op(OP_DELETE, '0);
            send_op(OP_LOOKUP, '1);
            for (int i = 0; i < 4; i++)
            begin
                send_op(OP_INSERT, chain_keys[i]);
            end
            send_op(OP_LOOKUP, chain_keys[1]);
            send_op(OP_DELETE, '0);
            send_op(OP_LOOKUP, chain_keys[1]);
            send_op(OP_INSERT, chain_keys[3]);
            send_op(OP_DELETE, '0);
            send_op(OP_LOOKUP, chain_keys[0]);
            send_op(OP_INSERT, chain_keys[1]);
            send_op(OP_INSERT, chain_keys[3]);
            wait_all_done();
        end
    endtask

    task automatic test_random(int count, int idle_pct, int stall_pct);
        int r;
        begin
            send_idle_pct = idle_pct;
            recv_stall_pct = stall_pct;
            for (int i = 0; i < count; i++)
            begin
                r = $urandom_range(99);
                if (r < 35)
                    send_op(OP_INSERT, $urandom_range(1) ? random_key() : pick_key());
                else if (r < 65)
                    send_op(OP_LOOKUP, pick_key());
                else if (r < 85)
                    send_op(OP_DELETE, random_key());
                else if (r < 92)
                    send_op(OP_SPARE, pick_key());
                else
                    send_op(OP_INSERT, key_in_bucket(bucket_of(pick_key())));
            end
            wait_all_done();
        end
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_asked++;
        for (int i = 0; i < 8; i++)
        begin
            send_op(i % 2 ? OP_LOOKUP : OP_INSERT, pick_key());
        end
        wait_all_done();
        for (int i = 0; i < 8; i++)
        begin
            send_op(OP_INSERT, random_key());
        end
        wait_all_done();
    endtask

    task automatic test_pool_full();
        logic [KEY_W-1:0] k;
        begin
            send_idle_pct = 13;
            recv_stall_pct = 13;
            while (live_count < NODES)
            begin
                send_op(OP_INSERT, random_key());
            end
            send_op(OP_INSERT, random_key());
            k = known_keys[$urandom_range(known_keys.size() - 1)];
            send_op(OP_INSERT, k);
            send_op(OP_DELETE, '0);
            send_op(OP_LOOKUP, k);
            send_op(OP_INSERT, random_key());
            send_op(OP_INSERT, random_key());
            send_op(OP_INSERT, '1);
            wait_all_done();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
            hold_taken <= 0;
        end
        else if (hold_asked != hold_taken)
        begin
            hold_taken <= hold_taken + 1;
            hold_left <= HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        map_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no expected result");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (found !== want.found)
                begin
                    $error("found: expected %0d, got %0d", want.found, found);
                    error_count++;
                end
                if (is_new !== want.is_new)
                begin
                    $error("is_new: expected %0d, got %0d", want.is_new, is_new);
                    error_count++;
                end
                if (handle !== want.handle)
                begin
                    $error("handle: expected %0d, got %0d", want.handle, handle);
                    error_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        operation = OP_LOOKUP;
        key = '0;
        error_count = 0;
        result_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_asked = 0;
        clear_model();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(60, 0, 0);
        test_random(60, 69, 0);
        test_random(60, 0, 69);
        test_random(60, 13, 13);
        test_backpressure();
        test_pool_full();
        wait_all_done();
        repeat (200) @(posedge clk);
        $display("Covered lookups, inserts, deletes, chain collisions, the spare opcode,");
        $display("a full pool and stalls on both sides: %0d results checked.", result_count);
        if (error_count == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
